// ----- rtl/triangle_tangent_frame_unit_assert.svh -----
// Assertion macros shared by the triangle tangent frame RTL.
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TTF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ttf assertion failed");
`define TTF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ttf reset assertion failed");
`else
`define TTF_ASSERT(lbl, prop)
`define TTF_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/ttf_pkg.sv -----
// Shared constants and types of the triangle tangent frame unit.
package ttf_pkg;

    localparam int FRAC_BITS = 12;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int ACC_W     = 48;
    localparam int Q14_ONE   = 16384;

    typedef struct packed {
        logic done;
        logic nonzero;
    } norm_stat_t;

endpackage

// ----- rtl/triangle_tangent_frame_unit.sv -----
// Top level of the triangle tangent frame unit: vertex buffer, sequencer and shared MAC.
//
// Vertices enter on the s_ channel (valid/ready), one word per vertex, three per
// triangle. The first two vertices of a triangle are only buffered.
// The third starts the frame computation; s_ready stays low until it ends.
// The frame is worked out by one shared 17x31 multiply-accumulate unit (dispatch,
// multiply and accumulate states per product) and one iterative normalizer (shift
// search, bit-serial square root, restoring divide) run up to three times. The time a
// third vertex takes is set mostly by the normalizer's shift search, square root and
// divide steps; no new vertex is taken until its frame is done.
// The frame leaves on the m_ channel from an output register; while that word
// waits for m_ready, new vertices are still taken and a following frame is held
// back until the register frees up.
// The APB port holds flip_v at byte address 0 (reset value 1); write it only
// while the block is idle. Reset is synchronous and active low; it clears the
// vertex phase, the uv flags and the output valid.
module triangle_tangent_frame_unit
    import ttf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_pos_x,
    input  logic signed [IN_W-1:0]  s_pos_y,
    input  logic signed [IN_W-1:0]  s_pos_z,
    input  logic signed [IN_W-1:0]  s_tex_u,
    input  logic signed [IN_W-1:0]  s_tex_v,
    input  logic                    s_uv_valid,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_normal_x,
    output logic signed [OUT_W-1:0] m_normal_y,
    output logic signed [OUT_W-1:0] m_normal_z,
    output logic signed [OUT_W-1:0] m_tangent_x,
    output logic signed [OUT_W-1:0] m_tangent_y,
    output logic signed [OUT_W-1:0] m_tangent_z,
    output logic signed [OUT_W-1:0] m_bitangent_x,
    output logic signed [OUT_W-1:0] m_bitangent_y,
    output logic signed [OUT_W-1:0] m_bitangent_z
);

    `include "triangle_tangent_frame_unit_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_ACC, S_NORM, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        K_MAC, K_NORM_N, K_NORM_T1, K_NORM_T2, K_OUT
    } uop_kind_t;

    typedef enum logic [2:0] {
        D_NONE, D_VEC, D_DET, D_NN, D_NT, D_BIT
    } dest_t;

    localparam logic [0:0] REG_FLIP_V = 1'b0;
    localparam int         UOP_W      = 6;

    state_t                  state_reg;
    logic [1:0]              phase_reg;
    logic                    flip_v_reg;
    logic signed [IN_W-1:0]  held_pos_reg [2][3];
    logic signed [IN_W-1:0]  held_uv_reg [2][2];
    logic                    held_flag_reg [2];

    logic signed [16:0]      e1_reg [3];
    logic signed [16:0]      e2_reg [3];
    logic signed [16:0]      du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic                    uvok_reg;

    logic [UOP_W-1:0]        uop_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] vec_reg [3];
    logic signed [ACC_W-1:0] det_reg;
    logic signed [30:0]      nn_reg;
    logic signed [30:0]      nt_reg;
    logic signed [OUT_W-1:0] nv_reg [3];
    logic signed [OUT_W-1:0] tv_reg [3];
    logic signed [OUT_W-1:0] t_reg [3];
    logic signed [OUT_W-1:0] bt_reg [3];
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_out_reg [9];

    uop_kind_t               kind;
    dest_t                   dest;
    logic [1:0]              didx;
    logic signed [16:0]      a_op;
    logic signed [30:0]      b_op;
    logic                    neg;
    logic                    first;
    logic                    dneg;
    logic                    tan_ok;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [23:0]      v_flip;
    logic signed [IN_W-1:0]  v_cur;
    logic                    s_fire;
    logic                    norm_start;
    norm_stat_t              nstat;
    logic signed [OUT_W-1:0] norm_out [3];
    logic [ACC_W-1:0]        bt_mag;
    logic [ACC_W-1:0]        bt_rnd;
    logic signed [OUT_W-1:0] bt_val;

    function automatic logic signed [30:0] w31(input logic signed [16:0] x);
        w31 = {{14{x[16]}}, x};
    endfunction

    function automatic logic signed [16:0] w17(input logic signed [15:0] x);
        w17 = {x[15], x};
    endfunction

    always_comb begin
        kind  = K_MAC;
        a_op  = '0;
        b_op  = '0;
        neg   = 1'b0;
        first = 1'b0;
        dest  = D_NONE;
        didx  = 2'd0;
        unique case (uop_reg)
            6'd0:  begin a_op = e1_reg[1]; b_op = w31(e2_reg[2]); first = 1'b1; end
            6'd1:  begin a_op = e1_reg[2]; b_op = w31(e2_reg[1]); neg = 1'b1;
                         dest = D_VEC; didx = 2'd0; end
            6'd2:  begin a_op = e1_reg[2]; b_op = w31(e2_reg[0]); first = 1'b1; end
            6'd3:  begin a_op = e1_reg[0]; b_op = w31(e2_reg[2]); neg = 1'b1;
                         dest = D_VEC; didx = 2'd1; end
            6'd4:  begin a_op = e1_reg[0]; b_op = w31(e2_reg[1]); first = 1'b1; end
            6'd5:  begin a_op = e1_reg[1]; b_op = w31(e2_reg[0]); neg = 1'b1;
                         dest = D_VEC; didx = 2'd2; end
            6'd6:  kind = K_NORM_N;
            6'd7:  begin a_op = du1_reg; b_op = w31(dv2_reg); first = 1'b1; end
            6'd8:  begin a_op = du2_reg; b_op = w31(dv1_reg); neg = 1'b1; dest = D_DET; end
            6'd9:  begin a_op = e1_reg[0]; b_op = w31(dv2_reg); neg = dneg; first = 1'b1; end
            6'd10: begin a_op = e2_reg[0]; b_op = w31(dv1_reg); neg = !dneg;
                         dest = D_VEC; didx = 2'd0; end
            6'd11: begin a_op = e1_reg[1]; b_op = w31(dv2_reg); neg = dneg; first = 1'b1; end
            6'd12: begin a_op = e2_reg[1]; b_op = w31(dv1_reg); neg = !dneg;
                         dest = D_VEC; didx = 2'd1; end
            6'd13: begin a_op = e1_reg[2]; b_op = w31(dv2_reg); neg = dneg; first = 1'b1; end
            6'd14: begin a_op = e2_reg[2]; b_op = w31(dv1_reg); neg = !dneg;
                         dest = D_VEC; didx = 2'd2; end
            6'd15: kind = K_NORM_T1;
            6'd16: begin a_op = w17(nv_reg[0]); b_op = w31(w17(nv_reg[0])); first = 1'b1; end
            6'd17: begin a_op = w17(nv_reg[1]); b_op = w31(w17(nv_reg[1])); end
            6'd18: begin a_op = w17(nv_reg[2]); b_op = w31(w17(nv_reg[2])); dest = D_NN; end
            6'd19: begin a_op = w17(nv_reg[0]); b_op = w31(w17(tv_reg[0])); first = 1'b1; end
            6'd20: begin a_op = w17(nv_reg[1]); b_op = w31(w17(tv_reg[1])); end
            6'd21: begin a_op = w17(nv_reg[2]); b_op = w31(w17(tv_reg[2])); dest = D_NT; end
            6'd22: begin a_op = w17(tv_reg[0]); b_op = nn_reg; first = 1'b1; end
            6'd23: begin a_op = w17(nv_reg[0]); b_op = nt_reg; neg = 1'b1;
                         dest = D_VEC; didx = 2'd0; end
            6'd24: begin a_op = w17(tv_reg[1]); b_op = nn_reg; first = 1'b1; end
            6'd25: begin a_op = w17(nv_reg[1]); b_op = nt_reg; neg = 1'b1;
                         dest = D_VEC; didx = 2'd1; end
            6'd26: begin a_op = w17(tv_reg[2]); b_op = nn_reg; first = 1'b1; end
            6'd27: begin a_op = w17(nv_reg[2]); b_op = nt_reg; neg = 1'b1;
                         dest = D_VEC; didx = 2'd2; end
            6'd28: kind = K_NORM_T2;
            6'd29: begin a_op = w17(nv_reg[1]); b_op = w31(w17(t_reg[2])); first = 1'b1; end
            6'd30: begin a_op = w17(nv_reg[2]); b_op = w31(w17(t_reg[1])); neg = 1'b1;
                         dest = D_BIT; didx = 2'd0; end
            6'd31: begin a_op = w17(nv_reg[2]); b_op = w31(w17(t_reg[0])); first = 1'b1; end
            6'd32: begin a_op = w17(nv_reg[0]); b_op = w31(w17(t_reg[2])); neg = 1'b1;
                         dest = D_BIT; didx = 2'd1; end
            6'd33: begin a_op = w17(nv_reg[0]); b_op = w31(w17(t_reg[1])); first = 1'b1; end
            6'd34: begin a_op = w17(nv_reg[1]); b_op = w31(w17(t_reg[0])); neg = 1'b1;
                         dest = D_BIT; didx = 2'd2; end
            default: kind = K_OUT;
        endcase
    end

    always_comb begin
        dneg    = det_reg[ACC_W-1];
        tan_ok  = uvok_reg && (det_reg != '0);
        acc_sum = (first ? ACC_W'(0) : acc_reg) + (neg ? (ACC_W'(0) - prod_reg) : prod_reg);
        bt_mag  = acc_sum[ACC_W-1] ? (ACC_W'(0) - acc_sum) : acc_sum;
        bt_rnd  = (bt_mag + ACC_W'(8192)) >> 14;
        if (bt_rnd > ACC_W'(Q14_ONE)) begin
            bt_rnd = ACC_W'(Q14_ONE);
        end
        bt_val  = acc_sum[ACC_W-1] ? (16'sd0 - $signed(bt_rnd[15:0])) : $signed(bt_rnd[15:0]);
        v_flip  = (24'sd1 <<< FRAC_BITS) - 24'(s_tex_v);
        if (!flip_v_reg) begin
            v_cur = s_tex_v;
        end else if (v_flip > 24'sd32767) begin
            v_cur = 16'sh7fff;
        end else if (v_flip < -24'sd32768) begin
            v_cur = 16'sh8000;
        end else begin
            v_cur = v_flip[15:0];
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign norm_start = (state_reg == S_DISPATCH)
                     && ((kind == K_NORM_N) || (kind == K_NORM_T2)
                         || ((kind == K_NORM_T1) && tan_ok));

    ttf_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (norm_start),
        .vec_in   (vec_reg),
        .stat     (nstat),
        .comp_out (norm_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            phase_reg        <= 2'd0;
            flip_v_reg       <= 1'b1;
            held_flag_reg[0] <= 1'b0;
            held_flag_reg[1] <= 1'b0;
            m_valid_reg      <= 1'b0;
            uop_reg          <= '0;
        end else begin
            if (psel && penable && pwrite && (paddr[2] == REG_FLIP_V)) begin
                flip_v_reg <= pwdata[0];
            end
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (phase_reg == 2'd2) begin
                            phase_reg <= 2'd0;
                            for (int k = 0; k < 3; k++) begin
                                e1_reg[k] <= w17(held_pos_reg[1][k]) - w17(held_pos_reg[0][k]);
                            end
                            e2_reg[0] <= w17(s_pos_x) - w17(held_pos_reg[0][0]);
                            e2_reg[1] <= w17(s_pos_y) - w17(held_pos_reg[0][1]);
                            e2_reg[2] <= w17(s_pos_z) - w17(held_pos_reg[0][2]);
                            du1_reg   <= w17(held_uv_reg[1][0]) - w17(held_uv_reg[0][0]);
                            dv1_reg   <= w17(held_uv_reg[1][1]) - w17(held_uv_reg[0][1]);
                            du2_reg   <= w17(s_tex_u) - w17(held_uv_reg[0][0]);
                            dv2_reg   <= w17(v_cur) - w17(held_uv_reg[0][1]);
                            uvok_reg  <= held_flag_reg[0] && held_flag_reg[1] && s_uv_valid;
                            uop_reg   <= '0;
                            state_reg <= S_DISPATCH;
                        end else begin
                            held_pos_reg[phase_reg[0]][0] <= s_pos_x;
                            held_pos_reg[phase_reg[0]][1] <= s_pos_y;
                            held_pos_reg[phase_reg[0]][2] <= s_pos_z;
                            held_uv_reg[phase_reg[0]][0]  <= s_tex_u;
                            held_uv_reg[phase_reg[0]][1]  <= v_cur;
                            held_flag_reg[phase_reg[0]]   <= s_uv_valid;
                            phase_reg <= (phase_reg == 2'd1) ? 2'd2 : 2'd1;
                        end
                    end
                end
                S_DISPATCH: begin
                    unique case (kind)
                        K_MAC: state_reg <= S_MUL;
                        K_NORM_N, K_NORM_T2: state_reg <= S_NORM;
                        K_NORM_T1: begin
                            if (tan_ok) begin
                                state_reg <= S_NORM;
                            end else begin
                                tv_reg[0] <= 16'(Q14_ONE);
                                tv_reg[1] <= '0;
                                tv_reg[2] <= '0;
                                uop_reg   <= uop_reg + UOP_W'(1);
                            end
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_MUL: begin
                    prod_reg  <= a_op * b_op;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_sum;
                    unique case (dest)
                        D_VEC:   vec_reg[didx] <= acc_sum;
                        D_DET:   det_reg <= acc_sum;
                        D_NN:    nn_reg <= acc_sum[30:0];
                        D_NT:    nt_reg <= acc_sum[30:0];
                        D_BIT:   bt_reg[didx] <= bt_val;
                        default: ;
                    endcase
                    uop_reg   <= uop_reg + UOP_W'(1);
                    state_reg <= S_DISPATCH;
                end
                S_NORM: begin
                    if (nstat.done) begin
                        unique case (kind)
                            K_NORM_N: begin
                                if (nstat.nonzero) begin
                                    nv_reg <= norm_out;
                                end else begin
                                    nv_reg[0] <= '0;
                                    nv_reg[1] <= '0;
                                    nv_reg[2] <= 16'(Q14_ONE);
                                end
                            end
                            K_NORM_T1: tv_reg <= norm_out;
                            default: begin
                                if (nstat.nonzero) begin
                                    t_reg <= norm_out;
                                end else begin
                                    t_reg[0] <= 16'(Q14_ONE);
                                    t_reg[1] <= '0;
                                    t_reg[2] <= '0;
                                end
                            end
                        endcase
                        uop_reg   <= uop_reg + UOP_W'(1);
                        state_reg <= S_DISPATCH;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int k = 0; k < 3; k++) begin
                            m_out_reg[k]     <= nv_reg[k];
                            m_out_reg[3 + k] <= t_reg[k];
                            m_out_reg[6 + k] <= bt_reg[k];
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pready        = 1'b1;
    assign prdata        = {31'd0, flip_v_reg};
    assign m_valid       = m_valid_reg;
    assign m_normal_x    = m_out_reg[0];
    assign m_normal_y    = m_out_reg[1];
    assign m_normal_z    = m_out_reg[2];
    assign m_tangent_x   = m_out_reg[3];
    assign m_tangent_y   = m_out_reg[4];
    assign m_tangent_z   = m_out_reg[5];
    assign m_bitangent_x = m_out_reg[6];
    assign m_bitangent_y = m_out_reg[7];
    assign m_bitangent_z = m_out_reg[8];

    `TTF_ASSERT(a_phase_legal, phase_reg != 2'd3)
    `TTF_ASSERT(a_out_wait, (state_reg == S_OUT && m_valid_reg && !m_ready) |=> state_reg == S_OUT)
    `TTF_ASSERT(a_normal_range, m_valid_reg |-> ($signed(m_normal_z) <= 16'sd16384 && $signed(m_normal_z) >= -16'sd16384))
    `TTF_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg))

endmodule

// ----- rtl/ttf_norm.sv -----
// Iterative vector normalizer producing a Q1.14 unit vector, or zeros for a zero input.
module ttf_norm
    import ttf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] vec_in [3],
    output norm_stat_t              stat,
    output logic signed [OUT_W-1:0] comp_out [3]
);

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_LOAD, N_DIV
    } nstate_t;

    nstate_t             state_reg;
    logic [ACC_W-1:0]    mag_reg [3];
    logic                neg_reg [3];
    logic [1:0]          sq_cnt_reg;
    logic [59:0]         prod_reg;
    logic [63:0]         rem_reg;
    logic [63:0]         root_reg;
    logic [4:0]          bit_reg;
    logic [1:0]          comp_reg;
    logic [45:0]         num_reg;
    logic [14:0]         q_reg;
    logic [3:0]          i_reg;
    logic signed [OUT_W-1:0] out_reg [3];
    logic                done_reg;
    logic                nz_reg;

    logic [ACC_W-1:0]    m_max;
    logic [63:0]         root_bit;
    logic [63:0]         root_try;
    logic [45:0]         div_sub;
    logic [15:0]         q_signed;

    always_comb begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max) begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max) begin
            m_max = mag_reg[2];
        end
        root_bit = 64'd1 << {bit_reg, 1'b0};
        root_try = root_reg + root_bit;
        div_sub  = {15'd0, root_reg[30:0]} << i_reg;
        q_signed = neg_reg[comp_reg] ? (16'd0 - {1'b0, q_reg}) : {1'b0, q_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            nz_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        for (int k = 0; k < 3; k++) begin
                            neg_reg[k] <= vec_in[k][ACC_W-1];
                            mag_reg[k] <= vec_in[k][ACC_W-1] ? (ACC_W'(0) - vec_in[k])
                                                             : vec_in[k];
                        end
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (m_max == '0) begin
                        for (int k = 0; k < 3; k++) begin
                            out_reg[k] <= '0;
                        end
                        done_reg  <= 1'b1;
                        nz_reg    <= 1'b0;
                        state_reg <= N_IDLE;
                    end else if (m_max[ACC_W-1:30] != '0) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= mag_reg[k] >> 1;
                        end
                    end else if (!m_max[29]) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= mag_reg[k] << 1;
                        end
                    end else begin
                        sq_cnt_reg <= 2'd0;
                        rem_reg    <= '0;
                        state_reg  <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (sq_cnt_reg != 2'd3) begin
                        prod_reg <= mag_reg[sq_cnt_reg][29:0] * mag_reg[sq_cnt_reg][29:0];
                    end
                    if (sq_cnt_reg != 2'd0) begin
                        rem_reg <= rem_reg + {4'd0, prod_reg};
                    end
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd3) begin
                        root_reg  <= '0;
                        bit_reg   <= 5'd31;
                        state_reg <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (rem_reg >= root_try) begin
                        rem_reg  <= rem_reg - root_try;
                        root_reg <= (root_reg >> 1) + root_bit;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        comp_reg  <= 2'd0;
                        state_reg <= N_LOAD;
                    end
                end
                N_LOAD: begin
                    num_reg   <= {2'd0, mag_reg[comp_reg][29:0], 14'd0}
                               + {16'd0, root_reg[30:1]};
                    q_reg     <= '0;
                    i_reg     <= 4'd14;
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    if (num_reg >= div_sub) begin
                        num_reg      <= num_reg - div_sub;
                        q_reg[i_reg] <= 1'b1;
                    end
                    i_reg <= i_reg - 4'd1;
                    if (i_reg == 4'd0) begin
                        if (num_reg >= div_sub) begin
                            out_reg[comp_reg] <= neg_reg[comp_reg]
                                ? (16'sd0 - $signed({1'b0, q_reg[14:1], 1'b1}))
                                : $signed({1'b0, q_reg[14:1], 1'b1});
                        end else begin
                            out_reg[comp_reg] <= $signed(q_signed);
                        end
                        if (comp_reg == 2'd2) begin
                            done_reg  <= 1'b1;
                            nz_reg    <= 1'b1;
                            state_reg <= N_IDLE;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_LOAD;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign stat.done    = done_reg;
    assign stat.nonzero = nz_reg;
    assign comp_out     = out_reg;

endmodule
